>>> rtl/core/pdmc_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider/multiplier calc package
// Shared widths, constants and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package pdmc_pkg;
    localparam int WANT_W = 21;
    localparam int REF_W  = 18;
    localparam int MIN_W  = 16;
    localparam int DIV_W  = 5;
    localparam int MUL_W  = 8;
    localparam int RATE_W = 26;
    localparam int PROD_W = 26;   // wanted * divider

    localparam logic [MIN_W-1:0]  MIN_INTER_RESET = 16'd5000;
    localparam logic [RATE_W-1:0] BAND3_FLOOR = 26'd501000;
    localparam logic [RATE_W-1:0] BAND2_FLOOR = 26'd251000;
    localparam logic [RATE_W-1:0] BAND1_FLOOR = 26'd126000;
    localparam logic [MUL_W-1:0]  MUL_MAX = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MUL_SAT  = 2'd1,
        ST_ZERO_REF = 2'd2
    } status_t;
endpackage
`default_nettype wire

>>> rtl/core/pdmc_div_cell.sv
// ----------------------------------------------------------------------------
// PLL calc restoring-division cell
// Retires one quotient bit of num/den per cycle while en is high; holds one chain slot.
// ----------------------------------------------------------------------------
`default_nettype none
module pdmc_div_cell #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 18,
    parameter int BIT   = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    input  wire logic [NUM_W-1:0] in_rem,
    input  wire logic [NUM_W-1:0] in_quo,
    output logic                  out_vld,
    output logic [NUM_W-1:0]      out_num,
    output logic [DEN_W-1:0]      out_den,
    output logic [NUM_W-1:0]      out_rem,
    output logic [NUM_W-1:0]      out_quo
);
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] rem_next, quo_next;
    logic             vld_reg;
    logic [NUM_W-1:0] num_reg, rem_reg, quo_reg;
    logic [DEN_W-1:0] den_reg;

    always_comb
    begin
        trial    = {in_rem, in_num[BIT]};
        rem_next = trial[NUM_W-1:0];
        quo_next = in_quo;
        if (trial >= {{(NUM_W+1-DEN_W){1'b0}}, in_den})
        begin
            rem_next       = NUM_W'(trial - {{(NUM_W+1-DEN_W){1'b0}}, in_den});
            quo_next[BIT]  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= in_num;
            den_reg <= in_den;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_num = num_reg;
    assign out_den = den_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;
endmodule
`default_nettype wire

>>> rtl/core/pdmc_divider.sv
// ----------------------------------------------------------------------------
// PLL calc pipelined divider
// A chain of division cells, one per quotient bit, MSB first; carries a
// side payload alongside so each quotient stays with its item.
// ----------------------------------------------------------------------------
`default_nettype none
module pdmc_divider #(
    parameter int NUM_W  = 27,
    parameter int DEN_W  = 18,
    parameter int SIDE_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_vld,
    output logic [NUM_W-1:0]       quo,
    output logic [SIDE_W-1:0]      out_side
);
    logic [NUM_W:0]             vld_c;
    logic [NUM_W:0][NUM_W-1:0]  num_c, rem_c, quo_c;
    logic [NUM_W:0][DEN_W-1:0]  den_c;
    logic [NUM_W:0][SIDE_W-1:0] side_c;

    assign vld_c[0]  = in_vld;
    assign num_c[0]  = num;
    assign den_c[0]  = den;
    assign rem_c[0]  = '0;
    assign quo_c[0]  = '0;
    assign side_c[0] = in_side;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        pdmc_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BIT(NUM_W-1-i)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_vld(vld_c[i]), .in_num(num_c[i]), .in_den(den_c[i]),
            .in_rem(rem_c[i]), .in_quo(quo_c[i]),
            .out_vld(vld_c[i+1]), .out_num(num_c[i+1]), .out_den(den_c[i+1]),
            .out_rem(rem_c[i+1]), .out_quo(quo_c[i+1])
        );
        logic [SIDE_W-1:0] side_reg;
        always_ff @(posedge clk)
        begin
            if (en)
                side_reg <= side_c[i];
        end
        assign side_c[i+1] = side_reg;
    end

    assign out_vld  = vld_c[NUM_W];
    assign quo      = quo_c[NUM_W];
    assign out_side = side_c[NUM_W];
endmodule
`default_nettype wire

>>> rtl/core/pll_divider_multiplier_calc_core.sv
// ----------------------------------------------------------------------------
// PLL divider/multiplier calc core
// Picks input divider and feedback multiplier for a wanted PLL rate.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word {reference_khz, wanted_rate_kbps};
//   m_axis returns one result word per request, in order.
//   cfg_valid/cfg_ready write min_intermediate_khz (reset 5000); write it
//   only while no request is in flight.
// Pipeline: 3 chained divider pipelines (18 + 27 + 27 cells) plus two glue
//   stages and the output register.
// Throughput: one word per cycle while not stalled. Every cell hands its
//   slot on each cycle the chain advances; the whole chain advances
//   whenever the output register is empty or being drained.
// Stall: when m_axis_tready is low and the output holds a word, the
//   chain freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset: all valid flags clear, the register returns to 5000.
// ----------------------------------------------------------------------------
`default_nettype none
module pll_divider_multiplier_calc_core #(
    parameter int MAX_DIVIDER = 31
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // bits 20:0 wanted_rate_kbps, 38:21 reference_khz
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // bits 15:0 pll_word, 20:16 divider, 28:21 multiplier, 30:29 band,
    // 56:31 achieved_rate_kbps, 58:57 status
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);
    import pdmc_pkg::*;

    localparam int SA_W = WANT_W + REF_W;           // stage A side payload
    localparam int SB_W = REF_W + DIV_W;            // stage B side payload
    localparam int SC_W = 1 + MUL_W + DIV_W + 2;    // stage C side payload

    logic [MIN_W-1:0] min_reg;
    logic             en;
    logic             out_vld_reg;
    logic [63:0]      out_data_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= MIN_INTER_RESET;
        else if (cfg_valid)
            min_reg <= cfg_data;
    end

    // Stage A: divider = ref / min, clamp to [1, MAX_DIVIDER].
    logic            a_vld;
    logic [17:0]     a_quo;
    logic [SA_W-1:0] a_side;
    pdmc_divider #(.NUM_W(REF_W), .DEN_W(MIN_W), .SIDE_W(SA_W)) u_div_a (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(s_axis_tvalid && s_axis_tready),
        .num(s_axis_tdata[38:21]), .den(min_reg),
        .in_side(s_axis_tdata[38:0]),
        .out_vld(a_vld), .quo(a_quo), .out_side(a_side)
    );

    logic [WANT_W-1:0] a_want;
    logic [REF_W-1:0]  a_ref;
    logic [DIV_W-1:0]  a_div;
    logic              b_in_vld;
    logic [SB_W-1:0]   b_in_side;
    logic [PROD_W-1:0] b_prod_reg;
    logic [REF_W-1:0]  b_ref_reg;
    logic [DIV_W-1:0]  b_div_reg;
    logic              b_vld_reg;

    always_comb
    begin
        a_want = a_side[WANT_W-1:0];
        a_ref  = a_side[SA_W-1:WANT_W];
        // min of zero: the cell chain yields all ones, which clamps to MAX.
        if (a_quo > 18'(MAX_DIVIDER))
            a_div = DIV_W'(MAX_DIVIDER);
        else if (a_quo == '0)
            a_div = DIV_W'(1);
        else
            a_div = a_quo[DIV_W-1:0];
    end

    // Register the product wanted*div + ref - 1 (wanted*div alone for ref of zero) ahead of stage B.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_prod_reg <= PROD_W'(a_want) * PROD_W'(a_div) + PROD_W'(a_ref)
                          - PROD_W'(a_ref != '0);
            b_ref_reg  <= a_ref;
            b_div_reg  <= a_div;
        end
    end

    assign b_in_vld  = b_vld_reg;
    assign b_in_side = {b_ref_reg, b_div_reg};

    // Stage B: multiplier = ceil(wanted*div / ref). Zero ref is flagged later.
    logic            b_vld;
    logic [26:0]     b_quo;
    logic [SB_W-1:0] b_side;
    pdmc_divider #(.NUM_W(27), .DEN_W(REF_W), .SIDE_W(SB_W)) u_div_b (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(b_in_vld), .num({1'b0, b_prod_reg}),
        .den(b_ref_reg == '0 ? REF_W'(1) : b_ref_reg),
        .in_side(b_in_side),
        .out_vld(b_vld), .quo(b_quo), .out_side(b_side)
    );

    logic [REF_W-1:0] bo_ref;
    logic [DIV_W-1:0] bo_div;
    logic [MUL_W-1:0] bo_mul;
    logic [1:0]       bo_st;
    logic             c_vld_reg;
    logic [26:0]      c_num_reg;
    logic [SC_W-1:0]  c_side_reg;
    logic [DIV_W-1:0] c_div_reg;

    always_comb
    begin
        bo_ref = b_side[SB_W-1:DIV_W];
        bo_div = b_side[DIV_W-1:0];
        bo_st  = ST_OK;
        bo_mul = b_quo[MUL_W-1:0];
        if (bo_ref == '0)
        begin
            bo_st  = ST_ZERO_REF;
            bo_mul = '0;
            bo_div = DIV_W'(1);
        end
        else if (b_quo > 27'(MUL_MAX))
        begin
            bo_st  = ST_MUL_SAT;
            bo_mul = MUL_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= b_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_num_reg  <= 27'(bo_ref) * 27'(bo_mul == '0 ? MUL_W'(1) : bo_mul);
            c_div_reg  <= bo_div;
            c_side_reg <= {bo_ref == '0, bo_mul, bo_div, bo_st};
        end
    end

    // Stage C: achieved rate = ref*mul_eff / div.
    logic            c_vld;
    logic [26:0]     c_quo;
    logic [SC_W-1:0] c_side;
    pdmc_divider #(.NUM_W(27), .DEN_W(DIV_W), .SIDE_W(SC_W)) u_div_c (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(c_vld_reg), .num(c_num_reg), .den(c_div_reg),
        .in_side(c_side_reg),
        .out_vld(c_vld), .quo(c_quo), .out_side(c_side)
    );

    logic              co_zero;
    logic [MUL_W-1:0]  co_mul;
    logic [DIV_W-1:0]  co_div;
    logic [1:0]        co_st;
    logic [RATE_W-1:0] co_rate;
    logic [1:0]        co_band;
    logic [15:0]       co_word;

    always_comb
    begin
        co_zero = c_side[SC_W-1];
        co_mul  = c_side[SC_W-2 -: MUL_W];
        co_div  = c_side[DIV_W+1:2];
        co_st   = c_side[1:0];
        co_rate = co_zero ? '0 : c_quo[RATE_W-1:0];
        if (co_rate >= BAND3_FLOOR)
            co_band = 2'd3;
        else if (co_rate >= BAND2_FLOOR)
            co_band = 2'd2;
        else if (co_rate >= BAND1_FLOOR)
            co_band = 2'd1;
        else
            co_band = 2'd0;
        co_word = {co_band, 1'b0, co_div, co_mul};
    end

    // Output register: hold the word until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= c_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {5'd0, co_st, co_rate, co_band, co_mul, co_div, co_word};
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("chain stalled with empty output");
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:16] != 5'd0)
        else $error("divider of zero");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[58:57] != 2'd3)
        else $error("bad status code");
`endif
endmodule
`default_nettype wire

>>> tb/pll_divider_multiplier_calc_core_test.sv
// ----------------------------------------------------------------------------
// PLL divider/multiplier calc core testbench
// Drives rate requests with random gaps and back-pressure, changes the
// minimum intermediate frequency between phases and checks every result
// word against a local prediction of word, divider, multiplier, band, rate and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import pdmc_pkg::*;

// Holds predicted result words in request order and compares them.
class pll_result_board;
    logic [63:0] pending[$];
    int          errors;
    logic [15:0] min_khz;

    function new();
        errors  = 0;
        min_khz = MIN_INTER_RESET;
    endfunction

    // Compute the result word for one request at the current setting.
    function logic [63:0] predict(logic [20:0] want, logic [17:0] refk);
        logic [63:0] div, mul, mul_eff, rate;
        logic [1:0]  band;
        status_t     st;
        logic [15:0] word;
        st = ST_OK;
        if (refk == 0)
            return {5'd0, ST_ZERO_REF, 26'd0, 2'd0, 8'd0, 5'd1, 16'h0100};
        if (min_khz == 0)
            div = 64'd31;
        else
        begin
            div = refk / min_khz;
            if (div < 1) div = 64'd1;
            if (div > 31) div = 64'd31;
        end
        mul = (want * div + refk - 1) / refk;
        if (mul > 255)
        begin
            mul = 64'd255;
            st  = ST_MUL_SAT;
        end
        mul_eff = (mul == 0) ? 64'd1 : mul;
        rate = (refk * mul_eff) / div;
        if (rate >= BAND3_FLOOR) band = 2'd3;
        else if (rate >= BAND2_FLOOR) band = 2'd2;
        else if (rate >= BAND1_FLOOR) band = 2'd1;
        else band = 2'd0;
        word = {band, 1'b0, div[4:0], mul[7:0]};
        return {5'd0, st, rate[25:0], band, mul[7:0], div[4:0], word};
    endfunction

    function void note_request(logic [39:0] data);
        pending.push_back(predict(data[20:0], data[38:21]));
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] exp_word);
        errors++;
        if (errors <= 30)
            $display("mismatch %s: got %h expected %h", what, got, exp_word);
    endfunction

    function void check_result(logic [63:0] got);
        logic [63:0] exp_word;
        if (pending.size() == 0)
        begin
            report("unexpected result", got, 64'd0);
            return;
        end
        exp_word = pending.pop_front();
        if (got[15:0] !== exp_word[15:0]) report("pll_word", got, exp_word);
        if (got[20:16] !== exp_word[20:16]) report("divider", got, exp_word);
        if (got[28:21] !== exp_word[28:21]) report("multiplier", got, exp_word);
        if (got[30:29] !== exp_word[30:29]) report("band", got, exp_word);
        if (got[56:31] !== exp_word[56:31]) report("achieved_rate", got, exp_word);
        if (got[58:57] !== exp_word[58:57]) report("status", got, exp_word);
    endfunction
endclass

module pll_divider_multiplier_calc_core_test;
    logic        clk;
    logic        rst_n;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;

    pll_result_board board;
    int          idle_cycles = 0;

    pll_divider_multiplier_calc_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sample accepted words at the rising edge; count idle cycles for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                board.note_request(s_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial
    begin
        wait (rst_n);
        wait (idle_cycles >= 2000);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: drop ready for a random gap before each word, often with no gap at all.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            m_axis_tready = 1'b0;
            repeat (gap) @(negedge clk);
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    // Send one request word after a random gap unless no_gap is set; hold it until accepted.
    task automatic send_request(logic [20:0] want, logic [17:0] refk, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, refk, want};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted word has drained.
    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // Write the minimum intermediate frequency while idle.
    task automatic write_min(logic [15:0] value);
        drain_block();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.min_khz = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random request biased toward sensible PLL ranges.
    task automatic random_request(bit no_gap);
        logic [20:0] want;
        logic [17:0] refk;
        case ($urandom_range(0, 9))
            0: refk = 18'd0;
            1: refk = 18'($urandom);
            2: refk = 18'($urandom_range(1, 200));
            default: refk = 18'($urandom_range(1000, 200000));
        endcase
        case ($urandom_range(0, 7))
            0: want = 21'd0;
            1: want = 21'($urandom);
            default: want = 21'($urandom_range(50000, 1200000));
        endcase
        send_request(want, refk, no_gap);
    endtask

    initial
    begin
        logic [15:0] settings[6];
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, zero reference, zero wanted rate, saturation, cap.
        send_request(21'd0, 18'd0, 0);
        send_request(21'h1FFFFF, 18'd0, 0);
        send_request(21'd0, 18'd25000, 0);
        send_request(21'h1FFFFF, 18'd1, 0);
        send_request(21'h1FFFFF, 18'h3FFFF, 0);
        send_request(21'd1, 18'h3FFFF, 0);
        send_request(21'd500000, 18'd24000, 0);
        send_request(21'd125999, 18'd19200, 0);
        send_request(21'd251000, 18'd26000, 0);
        send_request(21'd501000, 18'd27000, 0);
        send_request(21'd1000000, 18'd4999, 0);
        send_request(21'd1000000, 18'd5000, 0);
        send_request(21'd800000, 18'd200000, 0);
        send_request(21'd1, 18'd1, 0);

        // Hold off until every expected word has come, then resume.
        drain_block();

        settings = '{16'd65535, 16'd1000, 16'd0, 16'd1, 16'd12000, 16'd5000};
        for (int p = 0; p < 6; p++)
        begin
            write_min(settings[p]);
            for (int i = 0; i < 155; i++)
                random_request(p == 4);
        end
        send_request(21'h1FFFFF, 18'h3FFFF, 0);

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> files.f
rtl/core/pdmc_pkg.sv
rtl/core/pdmc_div_cell.sv
rtl/core/pdmc_divider.sv
rtl/core/pll_divider_multiplier_calc_core.sv
tb/pll_divider_multiplier_calc_core_test.sv
